@@ sv/counting_multiset_table_unit_assert.svh @@
// Assertion macros for the counting multiset table unit.
// Included by the RTL files that check their own logic; no dependencies.
`ifndef COUNTING_MULTISET_TABLE_UNIT_ASSERT_SVH
`define COUNTING_MULTISET_TABLE_UNIT_ASSERT_SVH

// check a condition in the same cycle as its trigger
`define CMT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// check a condition in the cycle after its trigger
`define CMT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/cmt_pkg.sv @@
// Shared types and constants of the counting multiset table unit.
// No dependencies; used by every module of the block.
package cmt_pkg;

   localparam int Entries   = 64;
   localparam int CountBits = 16;
   localparam int KeyBits   = 32;
   localparam int OutBits   = 16;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_SATURATED = 2'd2,
      ST_ABSENT    = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [KeyBits-1:0] key;
   } item_type;

   typedef struct packed {
      logic               found;
      logic [OutBits-1:0] count_after;
      logic [1:0]         status;
   } result_type;

endpackage

@@ sv/counting_multiset_table_unit.sv @@
// Top level of the counting multiset table unit: input register, slot table, result register.
// Depends on cmt_pkg, cmt_in_stage, cmt_table, cmt_out_stage and the assertion macro header.
//
//   channel  handshake            word
//   req      req_valid/req_stall  req_operation, req_key
//   rsp      rsp_valid/rsp_stall  rsp_found, rsp_count_after, rsp_status
//
// One word per cycle while no response is stalled: a request is compared against all 64 slots in the
// cycle after it is taken, and its response enters the result register once that register can advance.
// Reset clears all slot counts at once; keys are left unwritten.
// A stalled response holds the result register; an input register that holds a word then holds too,
// and req_stall rises until the response is taken.
`include "counting_multiset_table_unit_assert.svh"

module counting_multiset_table_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [15:0] rsp_count_after,
   output logic [1:0]  rsp_status
);

   cmt_pkg::item_type   req_item, item;
   cmt_pkg::result_type result, rsp_result;
   logic                item_vld, advance;

   assign req_item.operation = req_operation;
   assign req_item.key       = req_key;

   cmt_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .advance   (advance),
      .item_vld  (item_vld),
      .item      (item)
   );

   cmt_table u_table (
      .clock    (clock),
      .reset    (reset),
      .item_vld (item_vld),
      .item     (item),
      .update   (item_vld && advance),
      .result   (result)
   );

   cmt_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .item_vld   (item_vld),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_found       = rsp_result.found;
   assign rsp_count_after = rsp_result.count_after;
   assign rsp_status      = rsp_result.status;

   `CMT_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall && item_vld, "input stalled without a held response")

endmodule

@@ sv/cmt_in_stage.sv @@
// Input register of the counting multiset table unit.
// Depends on cmt_pkg for the item type.
module cmt_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cmt_pkg::item_type req_item,
   input  logic              advance,
   output logic              item_vld,
   output cmt_pkg::item_type item
);

   logic              vld_ff, vld_in;
   cmt_pkg::item_type item_ff, item_in;
   logic              load;

   assign req_stall = vld_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      vld_in  = vld_ff;
      item_in = item_ff;
      if (!req_stall) begin
         vld_in = req_valid;
      end
      if (load) begin
         item_in = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_vld = vld_ff;
   assign item     = item_ff;

endmodule

@@ sv/cmt_table.sv @@
// Slot table: parallel key compare, lowest-free-slot encoder and count update.
// Depends on cmt_pkg and the assertion macro header.
`include "counting_multiset_table_unit_assert.svh"

module cmt_table (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_vld,
   input  cmt_pkg::item_type   item,
   input  logic                update,
   output cmt_pkg::result_type result
);

   localparam int N  = cmt_pkg::Entries;
   localparam int CB = cmt_pkg::CountBits;

   logic [cmt_pkg::KeyBits-1:0] key_ff [N];
   logic [cmt_pkg::KeyBits-1:0] key_in [N];
   logic [CB-1:0]               cnt_ff [N];
   logic [CB-1:0]               cnt_in [N];

   logic [N-1:0]  occ, hit, free_vec, new_oh;
   logic [CB-1:0] cur_cnt, res_cnt;
   logic [31:0]   cnt_wide;
   logic          found, is_ins, is_rem;
   logic          do_inc, do_dec, do_new;
   cmt_pkg::status_type status;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         occ[i] = |cnt_ff[i];
         hit[i] = occ[i] && (key_ff[i] == item.key);
      end
      free_vec = ~occ;
      new_oh   = free_vec & (~free_vec + N'(1));
      cur_cnt  = '0;
      for (int i = 0; i < N; i++) begin
         cur_cnt = cur_cnt | (hit[i] ? cnt_ff[i] : '0);
      end
   end

   always_comb begin
      found   = |hit;
      is_ins  = (item.operation == cmt_pkg::OP_INSERT);
      is_rem  = (item.operation == cmt_pkg::OP_REMOVE);
      do_inc  = 1'b0;
      do_dec  = 1'b0;
      do_new  = 1'b0;
      res_cnt = cur_cnt;
      status  = cmt_pkg::ST_OK;
      if (is_ins) begin
         if (found) begin
            if (&cur_cnt) begin
               status = cmt_pkg::ST_SATURATED;
            end else begin
               do_inc  = 1'b1;
               res_cnt = cur_cnt + CB'(1);
            end
         end else if (|free_vec) begin
            do_new  = 1'b1;
            res_cnt = CB'(1);
         end else begin
            status = cmt_pkg::ST_FULL;
         end
      end else if (is_rem) begin
         if (found) begin
            do_dec  = 1'b1;
            res_cnt = cur_cnt - CB'(1);
         end else begin
            status = cmt_pkg::ST_ABSENT;
         end
      end
      cnt_wide           = 32'(res_cnt);
      result.found       = found;
      result.count_after = cnt_wide[cmt_pkg::OutBits-1:0];
      result.status      = status;
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         cnt_in[i] = cnt_ff[i];
         key_in[i] = key_ff[i];
         if (update && (hit[i] && (do_inc || do_dec))) begin
            cnt_in[i] = res_cnt;
         end
         if (update && do_new && new_oh[i]) begin
            cnt_in[i] = CB'(1);
            key_in[i] = item.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < N; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         key_ff[i] <= key_in[i];
      end
   end

   `CMT_ASSERT_NOW(a_hit_unique, clock, reset, item_vld, $onehot0(hit), "key held in two slots")
   `CMT_ASSERT_NOW(a_new_unique, clock, reset, item_vld, $onehot0(new_oh), "free encoder not one-hot")
   `CMT_ASSERT_NOW(a_full_real, clock, reset, item_vld && (status == cmt_pkg::ST_FULL), free_vec == '0, "full reported with a free slot")

endmodule

@@ sv/cmt_out_stage.sv @@
// Result register of the counting multiset table unit.
// Depends on cmt_pkg for the result type.
module cmt_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_vld,
   input  cmt_pkg::result_type result,
   output logic                advance,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cmt_pkg::result_type rsp_result
);

   logic                vld_ff, vld_in;
   cmt_pkg::result_type res_ff, res_in;

   assign advance = !vld_ff || !rsp_stall;

   always_comb begin
      vld_in = vld_ff;
      res_in = res_ff;
      if (advance) begin
         vld_in = item_vld;
         res_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid  = vld_ff;
   assign rsp_result = res_ff;

endmodule

@@ tb/sv/counting_multiset_table_unit_test.sv @@
// Self-checking testbench for counting_multiset_table_unit: drives insert, remove, query and spare-op
// words, predicts every response with its own copy of the slot table and compares field by field.
// Depends on cmt_pkg and the counting_multiset_table_unit RTL.
`timescale 1ns / 100ps

module counting_multiset_table_unit_test;

   localparam logic [1:0] OpSpare = 2'd3;
   localparam int QuietLimit = 4000;
   localparam logic [cmt_pkg::CountBits-1:0] CountMax = {cmt_pkg::CountBits{1'b1}};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = cmt_pkg::OP_QUERY;
   logic [31:0] req_key = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic [15:0] rsp_count_after;
   logic [1:0]  rsp_status;

   logic [cmt_pkg::KeyBits-1:0]   slot_key [cmt_pkg::Entries];
   logic [cmt_pkg::CountBits-1:0] slot_count [cmt_pkg::Entries];
   cmt_pkg::result_type           pending_results [$];
   logic [cmt_pkg::KeyBits-1:0]   key_pool [$];

   int  mismatches = 0;
   int  quiet_cycles = 0;
   int  stall_left = 0;
   bit  req_idle_on = 1'b1;
   bit  rsp_idle_on = 1'b1;
   logic hold_off = 1'b0;

   counting_multiset_table_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_count_after (rsp_count_after),
      .rsp_status      (rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic cmt_pkg::result_type apply_word(logic [1:0] operation,
                                                      logic [cmt_pkg::KeyBits-1:0] key);
      int hit;
      int free_idx;
      cmt_pkg::result_type r;
      hit = -1;
      free_idx = -1;
      for (int i = 0; i < cmt_pkg::Entries; i++) begin
         if (hit < 0 && slot_count[i] != '0 && slot_key[i] == key) hit = i;
         if (free_idx < 0 && slot_count[i] == '0) free_idx = i;
      end
      r.found = (hit >= 0);
      r.count_after = (hit >= 0) ? slot_count[hit] : '0;
      r.status = cmt_pkg::ST_OK;
      if (operation == cmt_pkg::OP_INSERT) begin
         if (hit >= 0) begin
            if (slot_count[hit] == CountMax) begin
               r.status = cmt_pkg::ST_SATURATED;
            end else begin
               slot_count[hit] = slot_count[hit] + 1'b1;
               r.count_after = slot_count[hit];
            end
         end else if (free_idx < 0) begin
            r.status = cmt_pkg::ST_FULL;
         end else begin
            slot_key[free_idx] = key;
            slot_count[free_idx] = cmt_pkg::CountBits'(1);
            r.count_after = cmt_pkg::OutBits'(1);
         end
      end else if (operation == cmt_pkg::OP_REMOVE) begin
         if (hit >= 0) begin
            slot_count[hit] = slot_count[hit] - 1'b1;
            r.count_after = slot_count[hit];
         end else begin
            r.status = cmt_pkg::ST_ABSENT;
         end
      end
      return r;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(99) < 85) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [1:0] pick_op(int insert_pct, int remove_pct);
      int r;
      r = $urandom_range(99);
      if (r < insert_pct) return cmt_pkg::OP_INSERT;
      if (r < insert_pct + remove_pct) return cmt_pkg::OP_REMOVE;
      if (r < 95) return cmt_pkg::OP_QUERY;
      return OpSpare;
   endfunction

   task automatic send_word(logic [1:0] operation, logic [cmt_pkg::KeyBits-1:0] key);
      int idle;
      idle = (req_idle_on && $urandom_range(2) == 0) ? pick_gap() : 0;
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= operation;
      req_key <= key;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(apply_word(operation, key));
   endtask

   task automatic check_word();
      cmt_pkg::result_type want;
      if (pending_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response: found %0b count %0d status %0d",
                     rsp_found, rsp_count_after, rsp_status);
         return;
      end
      want = pending_results.pop_front();
      if (rsp_found !== want.found || rsp_count_after !== want.count_after ||
          rsp_status !== want.status) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response mismatch: expected found %0b count %0d status %0d, got %0b %0d %0d",
                     want.found, want.count_after, want.status,
                     rsp_found, rsp_count_after, rsp_status);
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_word();
         if (hold_off) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (rsp_idle_on && $urandom_range(3) == 0) begin
            stall_left = pick_gap() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("counting_multiset_table_unit regression: fail");
         $finish;
      end
   end

   task automatic test_basic_ops();
      send_word(cmt_pkg::OP_INSERT, 32'h0000_0000);
      send_word(cmt_pkg::OP_INSERT, 32'h0000_0000);
      send_word(cmt_pkg::OP_QUERY,  32'h0000_0000);
      send_word(cmt_pkg::OP_INSERT, 32'hFFFF_FFFF);
      send_word(cmt_pkg::OP_QUERY,  32'hFFFF_FFFF);
      send_word(cmt_pkg::OP_REMOVE, 32'hFFFF_FFFF);
      send_word(cmt_pkg::OP_REMOVE, 32'hFFFF_FFFF);
      send_word(cmt_pkg::OP_QUERY,  32'hFFFF_FFFF);
      send_word(OpSpare,            32'h0000_0000);
      send_word(OpSpare,            32'h8000_0001);
      send_word(cmt_pkg::OP_INSERT, 32'h5555_5555);
      send_word(cmt_pkg::OP_INSERT, 32'hAAAA_AAAA);
      send_word(cmt_pkg::OP_QUERY,  32'h5555_5554);
      send_word(cmt_pkg::OP_REMOVE, 32'h0000_0000);
      send_word(cmt_pkg::OP_REMOVE, 32'h0000_0000);
      send_word(cmt_pkg::OP_QUERY,  32'h0000_0000);
      send_word(cmt_pkg::OP_INSERT, 32'h0000_0001);
      send_word(cmt_pkg::OP_REMOVE, 32'h7FFF_FFFF);
   endtask

   task automatic test_table_full();
      for (int i = 0; i < cmt_pkg::Entries; i++)
         send_word(cmt_pkg::OP_INSERT, 32'h1000_0000 + i);
      send_word(cmt_pkg::OP_INSERT, 32'h2000_0000);
      send_word(cmt_pkg::OP_QUERY,  32'h2000_0000);
      send_word(cmt_pkg::OP_REMOVE, 32'h2000_0000);
      send_word(cmt_pkg::OP_REMOVE, 32'h0000_0001);
      send_word(cmt_pkg::OP_INSERT, 32'h2000_0000);
      send_word(cmt_pkg::OP_INSERT, 32'h2000_0001);
      send_word(cmt_pkg::OP_INSERT, 32'h1000_0003);
   endtask

   task automatic test_repeat_counts();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (int i = 0; i < 24; i++) send_word(cmt_pkg::OP_INSERT, 32'h1000_0007);
      send_word(cmt_pkg::OP_REMOVE, 32'h1000_0007);
      send_word(cmt_pkg::OP_INSERT, 32'h1000_0007);
      send_word(cmt_pkg::OP_QUERY,  32'h1000_0007);
      for (int i = 0; i < cmt_pkg::Entries; i++) begin
         if (i != 7) send_word(cmt_pkg::OP_REMOVE, 32'h1000_0000 + i);
      end
      send_word(cmt_pkg::OP_REMOVE, 32'h1000_0003);
      send_word(cmt_pkg::OP_REMOVE, 32'h5555_5555);
      send_word(cmt_pkg::OP_REMOVE, 32'hAAAA_AAAA);
      send_word(cmt_pkg::OP_REMOVE, 32'h2000_0000);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      req_idle_on = 1'b0;
      hold_off <= 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off <= 1'b0;
         end
         for (int i = 0; i < 40; i++) send_word(pick_op(50, 30), 32'hC000_0000 + i % 8);
      join
      req_idle_on = 1'b1;
   endtask

   task automatic run_random(int count, int pool_size, int insert_pct, int remove_pct,
                             int wild_pct);
      logic [cmt_pkg::KeyBits-1:0] key;
      key_pool.delete();
      for (int i = 0; i < pool_size; i++) key_pool.push_back($urandom());
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < wild_pct) key = $urandom();
         else key = key_pool[$urandom_range(pool_size - 1)];
         send_word(pick_op(insert_pct, remove_pct), key);
      end
   endtask

   task automatic test_random_mix();
      run_random(350, 40, 45, 35, 5);
      run_random(300, 96, 65, 20, 5);
      run_random(250, 96, 25, 60, 5);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_random(200, 48, 45, 35, 40);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < cmt_pkg::Entries; i++) begin
         slot_key[i] = '0;
         slot_count[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_ops();
      test_table_full();
      test_repeat_counts();
      test_backpressure();
      test_random_mix();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("counting_multiset_table_unit regression: pass");
      end else begin
         $display("counting_multiset_table_unit regression: fail");
      end
      $finish;
   end

endmodule
